// ===== hw/rtl/complex_fir_centered_core_macros.svh =====
// ----------------------------------------------------------------------------
// complex_fir_centered_core_macros
// Assertion macros for the centered complex FIR core.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_FIR_CENTERED_CORE_MACROS_SVH
`define COMPLEX_FIR_CENTERED_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked outside reset
`define CFIR_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cfir assertion failed");

// checked on every edge, reset included
`define CFIR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cfir assertion failed");

`else

`define CFIR_ASSERT_RST(lbl, clk, rst_n, prop)
`define CFIR_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hw/rtl/cfir_pkg.sv =====
// ----------------------------------------------------------------------------
// cfir_pkg
// Shared types and constants of the centered complex FIR core.
// ----------------------------------------------------------------------------
package cfir_pkg;

    localparam int COEF_BITS    = 16;
    localparam int TAP_IDX_BITS = 6;
    localparam int NTAPS_BITS   = 7;
    localparam int SHIFT_BITS   = 5;
    localparam int SEEN_BITS    = 16;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [NTAPS_BITS-1:0] NUM_TAPS_RST  = 7'd1;
    localparam logic [SHIFT_BITS-1:0] OUT_SHIFT_RST = 5'd15;

    // register index, taken from paddr[2]
    localparam logic REG_NUM_TAPS  = 1'b0;
    localparam logic REG_OUT_SHIFT = 1'b1;

    localparam logic OP_TAP    = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic [NTAPS_BITS-1:0] num_taps;
        logic [SHIFT_BITS-1:0] out_shift;
    } t_cfg;

    typedef struct packed {
        logic clr;  // clear accumulators
        logic vld;  // operands valid
        logic fin;  // round accumulators
    } t_mac_ctl;

endpackage

// ===== hw/rtl/cfir_apb.sv =====
// ----------------------------------------------------------------------------
// cfir_apb
// APB register file: tap count and output shift.
// ----------------------------------------------------------------------------
module cfir_apb (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cfir_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cfir_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cfir_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output cfir_pkg::t_cfg                      o_cfg
);

    cfir_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_taps  <= cfir_pkg::NUM_TAPS_RST;
            r_cfg.out_shift <= cfir_pkg::OUT_SHIFT_RST;
        end else if (wr_en) begin
            case (paddr[2])
                cfir_pkg::REG_NUM_TAPS: begin
                    r_cfg.num_taps <= pwdata[cfir_pkg::NTAPS_BITS-1:0];
                end
                cfir_pkg::REG_OUT_SHIFT: begin
                    r_cfg.out_shift <= pwdata[cfir_pkg::SHIFT_BITS-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            cfir_pkg::REG_NUM_TAPS: begin
                prdata = cfir_pkg::APB_DATA_W'(r_cfg.num_taps);
            end
            cfir_pkg::REG_OUT_SHIFT: begin
                prdata = cfir_pkg::APB_DATA_W'(r_cfg.out_shift);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/cfir_mac.sv =====
// ----------------------------------------------------------------------------
// cfir_mac
// Shared complex multiply-accumulate with rounding shift and saturation.
// ----------------------------------------------------------------------------
module cfir_mac #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_TAPS    = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  cfir_pkg::t_mac_ctl                      i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]           i_x_i,
    input  logic signed [SAMPLE_BITS-1:0]           i_x_q,
    input  logic signed [cfir_pkg::COEF_BITS-1:0]   i_h_r,
    input  logic signed [cfir_pkg::COEF_BITS-1:0]   i_h_m,
    input  logic [cfir_pkg::SHIFT_BITS-1:0]         i_shift,
    output logic signed [SAMPLE_BITS-1:0]           o_y_i,
    output logic signed [SAMPLE_BITS-1:0]           o_y_q
);

    localparam int P_W   = SAMPLE_BITS + cfir_pkg::COEF_BITS;
    localparam int ACC_W = P_W + $clog2(MAX_TAPS) + 1;
    localparam int RND_W = ((ACC_W > 32) ? ACC_W : 32) + 2;
    localparam longint SAT_HI_L = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(SAT_HI_L);
    localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

    logic signed [P_W-1:0]   r_p_ir, r_p_qm, r_p_im, r_p_qr;
    logic                    r_p_vld;
    logic signed [ACC_W-1:0] r_acc_r, r_acc_i;
    logic signed [RND_W-1:0] r_rnd_r, r_rnd_i;
    logic signed [RND_W-1:0] half, sum_r, sum_i;

    function automatic logic signed [SAMPLE_BITS-1:0] sat(
        input logic signed [RND_W-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] res;
        if (v > SAT_HI) begin
            res = SAMPLE_BITS'(SAT_HI);
        end else if (v < SAT_LO) begin
            res = SAMPLE_BITS'(SAT_LO);
        end else begin
            res = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    always_comb begin
        if (i_shift == '0) begin
            half = '0;
        end else begin
            half = RND_W'(1) << (i_shift - cfir_pkg::SHIFT_BITS'(1));
        end
        sum_r = RND_W'(r_acc_r) + half;
        sum_i = RND_W'(r_acc_i) + half;
    end

    always_ff @(posedge i_clk) begin
        r_p_ir <= i_x_i * i_h_r;
        r_p_qm <= i_x_q * i_h_m;
        r_p_im <= i_x_i * i_h_m;
        r_p_qr <= i_x_q * i_h_r;
        if (i_ctl.fin) begin
            r_rnd_r <= sum_r >>> i_shift;
            r_rnd_i <= sum_i >>> i_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_acc_r <= '0;
            r_acc_i <= '0;
        end else begin
            r_p_vld <= i_ctl.vld;
            if (i_ctl.clr) begin
                r_acc_r <= '0;
                r_acc_i <= '0;
            end else if (r_p_vld) begin
                r_acc_r <= r_acc_r + ACC_W'(r_p_ir) - ACC_W'(r_p_qm);
                r_acc_i <= r_acc_i + ACC_W'(r_p_im) + ACC_W'(r_p_qr);
            end
        end
    end

    assign o_y_i = sat(r_rnd_r);
    assign o_y_q = sat(r_rnd_i);

endmodule

// ===== hw/rtl/complex_fir_centered_core.sv =====
// ----------------------------------------------------------------------------
// complex_fir_centered_core
// Block-wise complex FIR with same-length, tap-centered output.
// ----------------------------------------------------------------------------
// A tap-write transaction is stored and leaves the block idle. A sample
// transaction produces one output per center position it completes. For
// each output, one complex multiply-accumulate unit walks taps e to T - 1
// (T taps in use, e the output's distance behind the newest sample) one per
// cycle, fed by the coefficient and history memories, then drains its
// pipeline, rounds and saturates. A plain sample yields at most one output;
// the last sample of a block flushes up to D + 1 outputs back to back
// (D = T/2 for odd T, T/2 - 1 for even T, so at most MAX_TAPS/2). The block
// does not accept a transaction while it is computing. Results wait in a
// one-entry output register; while it is still held, the next result waits
// and the block stalls until it is taken.
// ----------------------------------------------------------------------------
`include "complex_fir_centered_core_macros.svh"

module complex_fir_centered_core #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [cfir_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [cfir_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [cfir_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic                                    i_op,
    input  logic [cfir_pkg::TAP_IDX_BITS-1:0]       i_tap_index,
    input  logic signed [cfir_pkg::COEF_BITS-1:0]   i_tap_real,
    input  logic signed [cfir_pkg::COEF_BITS-1:0]   i_tap_imag,
    input  logic signed [SAMPLE_BITS-1:0]           i_sample_i,
    input  logic signed [SAMPLE_BITS-1:0]           i_sample_q,
    input  logic                                    i_last_sample,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]           o_out_i,
    output logic signed [SAMPLE_BITS-1:0]           o_out_q,
    output logic                                    o_last_out
);

    localparam int IDX_W  = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int SEEN_W = cfir_pkg::SEEN_BITS;
    localparam int CB     = cfir_pkg::COEF_BITS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_RUN   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_FIN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    cfir_pkg::t_cfg     cfg;
    cfir_pkg::t_mac_ctl mac_ctl;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_wp, n_wp;
    logic [SEEN_W-1:0]   r_seen, n_seen;
    logic [SEEN_W-1:0]   r_m, n_m;
    logic [CNT_W-1:0]    r_t, n_t;
    logic [IDX_W-1:0]    r_e, n_e;
    logic [IDX_W-1:0]    r_e_end, n_e_end;
    logic                r_blk_last, n_blk_last;
    logic [IDX_W-1:0]    r_k, n_k;
    logic [IDX_W-1:0]    r_d, n_d;
    logic [IDX_W-1:0]    r_ptr, n_ptr;
    logic                r_drain, n_drain;

    logic                r_ovld;
    logic signed [SAMPLE_BITS-1:0] r_out_i, r_out_q;
    logic                r_out_last;

    logic [2*CB-1:0]          coef_mem [MAX_TAPS];
    logic [2*SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]      r_coef_vld;
    logic [2*CB-1:0]          r_coef;
    logic [2*SAMPLE_BITS-1:0] r_hist;
    logic                     r_cv, r_hv, r_rd_vld;

    logic               in_acc, out_take, out_load, issue, last_now, tap_ok;
    logic [CNT_W-1:0]   taps, dly;
    logic [IDX_W-1:0]   wp_inc, ptr_dec;
    logic signed [SAMPLE_BITS-1:0] x_i, x_q, y_i, y_q;
    logic signed [CB-1:0] h_r, h_m;

    cfir_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_take   = r_ovld && i_out_ready;
    assign out_load   = (r_state == S_OUT) && (!r_ovld || i_out_ready);
    assign issue      = (r_state == S_RUN);
    assign last_now   = r_blk_last && (r_e == r_e_end);
    assign tap_ok     = (int'(i_tap_index) < MAX_TAPS);
    assign wp_inc     = (r_wp == IDX_W'(MAX_TAPS - 1)) ? '0 : r_wp + IDX_W'(1);
    assign ptr_dec    = (r_ptr == '0) ? IDX_W'(MAX_TAPS - 1) : r_ptr - IDX_W'(1);

    always_comb begin
        if (cfg.num_taps == '0) begin
            taps = CNT_W'(1);
        end else if (int'(cfg.num_taps) > MAX_TAPS) begin
            taps = CNT_W'(MAX_TAPS);
        end else begin
            taps = CNT_W'(cfg.num_taps);
        end
        dly = taps[0] ? (taps >> 1) : (taps >> 1) - CNT_W'(1);
    end

    always_comb begin
        n_state    = r_state;
        n_wp       = r_wp;
        n_seen     = r_seen;
        n_m        = r_m;
        n_t        = r_t;
        n_e        = r_e;
        n_e_end    = r_e_end;
        n_blk_last = r_blk_last;
        n_k        = r_k;
        n_d        = r_d;
        n_ptr      = r_ptr;
        n_drain    = r_drain;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_op == cfir_pkg::OP_SAMPLE)) begin
                    n_wp       = wp_inc;
                    n_m        = r_seen;
                    n_t        = taps;
                    n_blk_last = i_last_sample;
                    n_e_end    = i_last_sample ? IDX_W'(dly) : '0;
                    if (i_last_sample) begin
                        n_seen  = '0;
                        n_state = S_START;
                        if (r_seen >= SEEN_W'(dly)) begin
                            n_e = '0;
                        end else begin
                            n_e = IDX_W'(SEEN_W'(dly) - r_seen);
                        end
                    end else begin
                        n_e = '0;
                        if (r_seen != '1) begin
                            n_seen = r_seen + SEEN_W'(1);
                        end
                        if (r_seen >= SEEN_W'(dly)) begin
                            n_state = S_START;
                        end
                    end
                end
            end
            S_START: begin
                n_k     = r_e;
                n_d     = '0;
                n_ptr   = r_wp;
                n_state = S_RUN;
            end
            S_RUN: begin
                n_k   = r_k + IDX_W'(1);
                n_d   = r_d + IDX_W'(1);
                n_ptr = ptr_dec;
                if (CNT_W'(r_k) == r_t - CNT_W'(1)) begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    if (r_e == r_e_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_e     = r_e + IDX_W'(1);
                        n_state = S_START;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wp       <= '0;
            r_seen     <= '0;
            r_m        <= '0;
            r_t        <= CNT_W'(1);
            r_e        <= '0;
            r_e_end    <= '0;
            r_blk_last <= 1'b0;
            r_k        <= '0;
            r_d        <= '0;
            r_ptr      <= '0;
            r_drain    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wp       <= n_wp;
            r_seen     <= n_seen;
            r_m        <= n_m;
            r_t        <= n_t;
            r_e        <= n_e;
            r_e_end    <= n_e_end;
            r_blk_last <= n_blk_last;
            r_k        <= n_k;
            r_d        <= n_d;
            r_ptr      <= n_ptr;
            r_drain    <= n_drain;
            r_rd_vld   <= issue;
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (out_take) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // coefficient store, valid bit per entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
        end else if (in_acc && (i_op == cfir_pkg::OP_TAP) && tap_ok) begin
            r_coef_vld[IDX_W'(i_tap_index)] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_op == cfir_pkg::OP_TAP) && tap_ok) begin
            coef_mem[IDX_W'(i_tap_index)] <= {i_tap_real, i_tap_imag};
        end
        r_coef <= coef_mem[r_k];
        r_cv   <= r_coef_vld[r_k];
    end

    // history ring, newest entry at r_wp
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_op == cfir_pkg::OP_SAMPLE)) begin
            hist_mem[wp_inc] <= {i_sample_i, i_sample_q};
        end
        r_hist <= hist_mem[r_ptr];
        r_hv   <= (SEEN_W'(r_d) <= r_m);
    end

    assign x_i = r_hv ? r_hist[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
    assign x_q = r_hv ? r_hist[SAMPLE_BITS-1:0] : '0;
    assign h_r = r_cv ? r_coef[2*CB-1:CB] : '0;
    assign h_m = r_cv ? r_coef[CB-1:0] : '0;

    assign mac_ctl.clr = (r_state == S_START);
    assign mac_ctl.vld = r_rd_vld;
    assign mac_ctl.fin = (r_state == S_FIN);

    cfir_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_TAPS    (MAX_TAPS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_x_i   (x_i),
        .i_x_q   (x_q),
        .i_h_r   (h_r),
        .i_h_m   (h_m),
        .i_shift (cfg.out_shift),
        .o_y_i   (y_i),
        .o_y_q   (y_q)
    );

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_i    <= y_i;
            r_out_q    <= y_q;
            r_out_last <= last_now;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_i     = r_out_i;
    assign o_out_q     = r_out_q;
    assign o_last_out  = r_out_last;

    `CFIR_ASSERT_RST(a_tap_in_range, i_clk, i_rst_n, (r_state == S_RUN) |-> (CNT_W'(r_k) < r_t))
    `CFIR_ASSERT_RST(a_block_clear, i_clk, i_rst_n, (in_acc && i_op && i_last_sample) |=> (r_seen == '0))
    `CFIR_ASSERT_RST(a_flush_end, i_clk, i_rst_n, (out_load && last_now) |=> (r_state == S_IDLE))
    `CFIR_ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n) |=> (!r_ovld && (r_state == S_IDLE)))

endmodule

// ===== bench/complex_fir_centered_core_tb.sv =====
// ----------------------------------------------------------------------------
// complex_fir_centered_core_tb
// Self-checking bench for the centered complex FIR core. A directed part
// covers tap and sample extremes, short blocks, a long block and out-of-range
// tap counts. Random phases then reprogram the registers over the APB port
// and stream tap writes and sample blocks of random length. A local predictor
// tracks taps and history and queues the expected outputs. The output stream
// is checked in order against that queue, under random stalls on both sides.
// ----------------------------------------------------------------------------
module complex_fir_centered_core_tb;

    localparam int MAX_TAPS      = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT       = 60;
    localparam int PHASE_ITEMS   = 33;

    typedef struct {
        logic                                       op;
        logic [cfir_pkg::TAP_IDX_BITS-1:0]          tap_index;
        logic signed [cfir_pkg::COEF_BITS-1:0]      tap_real;
        logic signed [cfir_pkg::COEF_BITS-1:0]      tap_imag;
        logic signed [SAMPLE_BITS-1:0]              sample_i;
        logic signed [SAMPLE_BITS-1:0]              sample_q;
        logic                                       last_sample;
    } t_fir_xact;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0]  out_i;
        logic signed [SAMPLE_BITS-1:0]  out_q;
        logic                           last_out;
    } t_fir_result;

    logic                                       i_clk = 1'b0;
    logic                                       i_rst_n = 1'b0;
    logic                                       psel = 1'b0;
    logic                                       penable = 1'b0;
    logic                                       pwrite = 1'b0;
    logic [cfir_pkg::APB_ADDR_W-1:0]            paddr = '0;
    logic [cfir_pkg::APB_DATA_W-1:0]            pwdata = '0;
    logic [cfir_pkg::APB_DATA_W-1:0]            prdata;
    logic                                       pready;
    logic                                       i_in_valid = 1'b0;
    logic                                       o_in_ready;
    logic                                       i_op = 1'b0;
    logic [cfir_pkg::TAP_IDX_BITS-1:0]          i_tap_index = '0;
    logic signed [cfir_pkg::COEF_BITS-1:0]      i_tap_real = '0;
    logic signed [cfir_pkg::COEF_BITS-1:0]      i_tap_imag = '0;
    logic signed [SAMPLE_BITS-1:0]              i_sample_i = '0;
    logic signed [SAMPLE_BITS-1:0]              i_sample_q = '0;
    logic                                       i_last_sample = 1'b0;
    logic                                       o_out_valid;
    logic                                       i_out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0]              o_out_i;
    logic signed [SAMPLE_BITS-1:0]              o_out_q;
    logic                                       o_last_out;

    t_fir_xact   pending_xacts[$];
    t_fir_result expected_results[$];

    logic signed [cfir_pkg::COEF_BITS-1:0]  coef_re [MAX_TAPS];
    logic signed [cfir_pkg::COEF_BITS-1:0]  coef_im [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]          hist_i  [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]          hist_q  [MAX_TAPS];
    int unsigned                            seen_cnt = 0;
    logic [cfir_pkg::NTAPS_BITS-1:0]        cfg_taps = cfir_pkg::NUM_TAPS_RST;
    logic [cfir_pkg::SHIFT_BITS-1:0]        cfg_shift = cfir_pkg::OUT_SHIFT_RST;

    int          err_cnt = 0;
    int          results_seen = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned cycle_cnt = 0;
    int          queued_cnt = 0;
    logic        steady_span;

    complex_fir_centered_core #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_tap_index   (i_tap_index),
        .i_tap_real    (i_tap_real),
        .i_tap_imag    (i_tap_imag),
        .i_sample_i    (i_sample_i),
        .i_sample_q    (i_sample_q),
        .i_last_sample (i_last_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_i       (o_out_i),
        .o_out_q       (o_out_q),
        .o_last_out    (o_last_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    assign steady_span = (cycle_cnt >= 3000) && (cycle_cnt < 4500);

    // ---------------- predictor ----------------
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(longint acc);
        longint y;
        if (cfg_shift != 0) acc = acc + (longint'(1) <<< (cfg_shift - 1));
        y = acc >>> cfg_shift;
        if (y > 32767) y = 32767;
        else if (y < -32768) y = -32768;
        return y[SAMPLE_BITS-1:0];
    endfunction

    function automatic t_fir_result filter_point(int unsigned e, int unsigned t, logic lst);
        longint      acc_re;
        longint      acc_im;
        t_fir_result r;
        acc_re = 0;
        acc_im = 0;
        for (int unsigned k = e; k < t; k++) begin
            acc_re += longint'(hist_i[k-e]) * longint'(coef_re[k])
                    - longint'(hist_q[k-e]) * longint'(coef_im[k]);
            acc_im += longint'(hist_i[k-e]) * longint'(coef_im[k])
                    + longint'(hist_q[k-e]) * longint'(coef_re[k]);
        end
        r.out_i    = round_sat(acc_re);
        r.out_q    = round_sat(acc_im);
        r.last_out = lst;
        return r;
    endfunction

    function automatic void advance_filter(t_fir_xact x);
        int unsigned t;
        int unsigned dly;
        int unsigned m;
        int unsigned e0;
        if (x.op == cfir_pkg::OP_TAP) begin
            coef_re[x.tap_index] = x.tap_real;
            coef_im[x.tap_index] = x.tap_imag;
            return;
        end
        for (int j = MAX_TAPS - 1; j > 0; j--) begin
            hist_i[j] = hist_i[j-1];
            hist_q[j] = hist_q[j-1];
        end
        hist_i[0] = x.sample_i;
        hist_q[0] = x.sample_q;
        t = (cfg_taps == 0) ? 1 : (cfg_taps > MAX_TAPS) ? MAX_TAPS : cfg_taps;
        dly = (t % 2 == 1) ? t / 2 : t / 2 - 1;
        m = seen_cnt;
        if (seen_cnt < 'hFFFF) seen_cnt++;
        if (!x.last_sample) begin
            if (m >= dly) expected_results.push_back(filter_point(0, t, 1'b0));
        end else begin
            e0 = (m >= dly) ? 0 : dly - m;
            for (int unsigned e = e0; e <= dly; e++)
                expected_results.push_back(filter_point(e, t, e == dly));
            for (int j = 0; j < MAX_TAPS; j++) begin
                hist_i[j] = '0;
                hist_q[j] = '0;
            end
            seen_cnt = 0;
        end
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic [15:0] rand_word();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void enqueue(t_fir_xact x);
        pending_xacts.push_back(x);
        queued_cnt++;
    endfunction

    function automatic void push_tap(int idx, logic [15:0] re, logic [15:0] im);
        t_fir_xact x;
        x.op          = cfir_pkg::OP_TAP;
        x.tap_index   = cfir_pkg::TAP_IDX_BITS'(idx);
        x.tap_real    = re;
        x.tap_imag    = im;
        x.sample_i    = SAMPLE_BITS'($urandom);
        x.sample_q    = SAMPLE_BITS'($urandom);
        x.last_sample = 1'($urandom_range(1));
        enqueue(x);
    endfunction

    function automatic void push_sample(logic [15:0] si, logic [15:0] sq, logic lst);
        t_fir_xact x;
        x.op          = cfir_pkg::OP_SAMPLE;
        x.tap_index   = cfir_pkg::TAP_IDX_BITS'($urandom);
        x.tap_real    = cfir_pkg::COEF_BITS'($urandom);
        x.tap_imag    = cfir_pkg::COEF_BITS'($urandom);
        x.sample_i    = si;
        x.sample_q    = sq;
        x.last_sample = lst;
        enqueue(x);
    endfunction

    function automatic void push_random_block(int len);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(99) < 3)
                push_tap($urandom_range(MAX_TAPS - 1), rand_word(), rand_word());
            push_sample(rand_word(), rand_word(), n == len - 1);
        end
    endfunction

    task automatic write_reg(logic sel, logic [cfir_pkg::APB_DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == cfir_pkg::REG_NUM_TAPS) cfg_taps = val[cfir_pkg::NTAPS_BITS-1:0];
        else cfg_shift = val[cfir_pkg::SHIFT_BITS-1:0];
    endtask

    task automatic drain();
        while (pending_xacts.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        logic      fire;
        logic      go;
        logic      held;
        t_fir_xact nx;
        fire = i_rst_n && i_in_valid && o_in_ready;
        if (fire) advance_filter(pending_xacts.pop_front());
        held = i_in_valid && !fire;
        if (held) go = 1'b1;
        else go = i_rst_n && pending_xacts.size() != 0
                  && (steady_span || $urandom_range(99) >= 35);
        i_in_valid <= go;
        if (go && !held) begin
            nx = pending_xacts[0];
            i_op          <= nx.op;
            i_tap_index   <= nx.tap_index;
            i_tap_real    <= nx.tap_real;
            i_tap_imag    <= nx.tap_imag;
            i_sample_i    <= nx.sample_i;
            i_sample_q    <= nx.sample_q;
            i_last_sample <= nx.last_sample;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_fir_result exp_r;
        logic        rdy;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected output, exp none, got i=%0d q=%0d l=%0b",
                         $time, o_out_i, o_out_q, o_last_out);
                err_cnt++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out_i !== exp_r.out_i || o_out_q !== exp_r.out_q
                    || o_last_out !== exp_r.last_out) begin
                    $display("%0t: mismatch exp i=%0d q=%0d l=%0b got i=%0d q=%0d l=%0b",
                             $time, exp_r.out_i, exp_r.out_q, exp_r.last_out,
                             o_out_i, o_out_q, o_last_out);
                    err_cnt++;
                end
            end
            results_seen++;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            // long back-pressure so the core fills up and stalls its input
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            rdy = 1'b0;
        end else begin
            rdy = i_rst_n && (steady_span || $urandom_range(99) >= 35);
        end
        i_out_ready <= rdy;
    end

    // ---------------- sequence ----------------
    initial begin
        int t_sel;
        int phase_start;
        int blk_len;
        for (int j = 0; j < MAX_TAPS; j++) begin
            coef_re[j] = '0;
            coef_im[j] = '0;
            hist_i[j]  = '0;
            hist_q[j]  = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // five taps, extremes, one unused high tap
        write_reg(cfir_pkg::REG_NUM_TAPS, 5);
        write_reg(cfir_pkg::REG_OUT_SHIFT, 15);
        push_tap(0, 16'h7FFF, 16'h8000);
        push_tap(1, 16'h8000, 16'h7FFF);
        push_tap(2, 16'h4000, 16'h0000);
        push_tap(3, 16'h0000, 16'hC000);
        push_tap(4, 16'hFFFF, 16'h0001);
        push_tap(63, 16'h7FFF, 16'h7FFF);
        push_sample(16'h7FFF, 16'h8000, 1'b1);
        push_sample(16'h8000, 16'h8000, 1'b0);
        push_sample(16'h7FFF, 16'h7FFF, 1'b1);
        push_sample(16'h8000, 16'h7FFF, 1'b0);
        push_sample(16'h7FFF, 16'h8000, 1'b0);
        push_sample(16'h0000, 16'hFFFF, 1'b0);
        push_sample(16'h1234, 16'hEDCB, 1'b0);
        push_sample(16'h8000, 16'h8000, 1'b0);
        push_sample(16'h7FFF, 16'h7FFF, 1'b0);
        push_sample(16'h0001, 16'h8001, 1'b1);
        drain();

        // full tap set, no shift: saturation
        write_reg(cfir_pkg::REG_NUM_TAPS, 64);
        write_reg(cfir_pkg::REG_OUT_SHIFT, 0);
        push_sample(16'h7FFF, 16'h8000, 1'b0);
        push_sample(16'h8000, 16'h7FFF, 1'b0);
        push_sample(16'h7FFF, 16'h7FFF, 1'b1);
        drain();

        // zero taps acts as one, widest shift
        write_reg(cfir_pkg::REG_NUM_TAPS, 0);
        write_reg(cfir_pkg::REG_OUT_SHIFT, 31);
        push_sample(16'h8000, 16'h8000, 1'b0);
        push_sample(16'h7FFF, 16'h7FFF, 1'b1);
        drain();

        // tap count above range, short block
        write_reg(cfir_pkg::REG_NUM_TAPS, 127);
        write_reg(cfir_pkg::REG_OUT_SHIFT, 14);
        push_sample(16'h7FFF, 16'h8000, 1'b0);
        push_sample(16'h8000, 16'h7FFF, 1'b0);
        push_sample(16'h5555, 16'hAAAA, 1'b0);
        push_sample(16'hAAAA, 16'h5555, 1'b1);
        drain();

        // long block, history wraps past the full tap span
        write_reg(cfir_pkg::REG_NUM_TAPS, 64);
        write_reg(cfir_pkg::REG_OUT_SHIFT, 15);
        push_random_block(70);
        drain();

        for (int p = 0; p < 8; p++) begin
            t_sel = $urandom_range(3);
            case (t_sel)
                0:       write_reg(cfir_pkg::REG_NUM_TAPS, $urandom_range(127));
                1:       write_reg(cfir_pkg::REG_NUM_TAPS, $urandom_range(1, 8));
                default: write_reg(cfir_pkg::REG_NUM_TAPS, $urandom_range(9, 64));
            endcase
            if ($urandom_range(9) == 0) write_reg(cfir_pkg::REG_OUT_SHIFT, $urandom_range(31));
            else write_reg(cfir_pkg::REG_OUT_SHIFT, $urandom_range(13, 16));
            phase_start = queued_cnt;
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(3) == 0)
                    push_tap($urandom_range(MAX_TAPS - 1), rand_word(), rand_word());
                else
                    push_tap($urandom_range((cfg_taps == 0 || cfg_taps > MAX_TAPS) ?
                             MAX_TAPS - 1 : cfg_taps - 1), rand_word(), rand_word());
            end
            while (queued_cnt - phase_start < PHASE_ITEMS) begin
                blk_len = $urandom_range(1, 24);
                if (blk_len > PHASE_ITEMS - (queued_cnt - phase_start))
                    blk_len = PHASE_ITEMS - (queued_cnt - phase_start);
                push_random_block(blk_len);
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #48_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== complex_fir_centered_core.f =====
+incdir+hw/rtl
hw/rtl/cfir_pkg.sv
hw/rtl/cfir_apb.sv
hw/rtl/cfir_mac.sv
hw/rtl/complex_fir_centered_core.sv
bench/complex_fir_centered_core_tb.sv
